// ===== design/nspe_pkg.sv =====
// Shared constants, types and fixed-point helpers for the NURBS surface point evaluator.
// No dependencies; the core refers to this package by scoped names.
`default_nettype none

package nspe_pkg;

    localparam int MAX_POINTS = 16;
    localparam int MAX_DEGREE = 3;
    localparam int FRAC_BITS  = 16;
    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int NET_DEPTH  = MAX_POINTS * MAX_POINTS;
    localparam int BASIS_LEN  = KNOT_DEPTH - 1;
    localparam int KA_W       = $clog2(KNOT_DEPTH);
    localparam int NA_W       = $clog2(NET_DEPTH);
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int PADDR_W    = 4;

    localparam logic signed [31:0] FIX_ONE = 32'(64'd1 << FRAC_BITS);
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ACT_LOAD_U  = 2'd0,
        ACT_LOAD_V  = 2'd1,
        ACT_LOAD_PT = 2'd2,
        ACT_EVAL    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_DEGREE_U = 2'd0,
        REG_DEGREE_V = 2'd1,
        REG_POINTS_U = 2'd2,
        REG_POINTS_V = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BSTEP,
        ST_KREAD,
        ST_BCASE,
        ST_BTERM,
        ST_DIV,
        ST_MUL,
        ST_MACC,
        ST_BROT,
        ST_ACC_UV,
        ST_ACC_W,
        ST_ACC_A,
        ST_ACC_X,
        ST_ACC_Y,
        ST_ACC_Z,
        ST_ACC_NXT,
        ST_FIN,
        ST_FSTART,
        ST_FDIV,
        ST_FSTORE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [31:0] w;
    } t_point;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'(S32_MAX)) begin
            return S32_MAX;
        end else if (x < 64'(S32_MIN)) begin
            return S32_MIN;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return b[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    // Applies the sign to a quotient magnitude and saturates to 32 bits.
    function automatic logic signed [31:0] sat_div(input logic [63:0] q, input logic neg);
        if (!neg) begin
            return (q > 64'h7fff_ffff) ? S32_MAX : q[31:0];
        end
        return (q > 64'h8000_0000) ? S32_MIN : 32'(-q[31:0]);
    endfunction

    // A point count of zero reads as one, and counts above the limit are clamped.
    function automatic logic [4:0] eff_points(input logic [4:0] p);
        if (p == 5'd0) begin
            return 5'd1;
        end else if (p > 5'(MAX_POINTS)) begin
            return 5'(MAX_POINTS);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/nspe_item_if.sv =====
// Handshake interfaces for the input item channel and the result channel.
// Depends on nothing; payload widths follow the block's field list.
`default_nettype none

interface nspe_item_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic        [7:0]  slot;
    logic signed [31:0] knot;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [31:0] weight;
    logic signed [31:0] param_u;
    logic signed [31:0] param_v;

    modport source (output valid, action, slot, knot, px, py, pz, weight, param_u, param_v,
                    input ready);
    modport sink (input valid, action, slot, knot, px, py, pz, weight, param_u, param_v,
                  output ready);
endinterface

interface nspe_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               status;

    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

`default_nettype wire

// ===== design/nurbs_surface_point_eval_core.sv =====
// NURBS surface point evaluator: knot and control net memories, basis sequencer, divider.
// Depends on nspe_pkg and the channel interfaces in nspe_item_if.sv.
//
// Usage. Items arrive on i_item as valid/ready transfers. Action "load u knot" and
// "load v knot" write the knot memories (slots beyond the store are dropped), "load
// control point" writes one entry of the control net at row*points_v+column, and
// "evaluate" computes one surface point that leaves on o_result. Loads produce no
// result. The APB port holds degree_u, degree_v, points_u and points_v; the user must
// see that it is written only while the block is idle, as the block does not enforce it.
//
// Operation. One item is processed at a time. An evaluation first builds the u basis
// and then the v basis level by level; each basis value that needs the recursion costs
// knot reads plus up to two serial divisions, so an axis takes (degree+1)*19 steps.
// The weighted sum then walks the control net point by point, and three output
// divisions by the weight sum follow unless that sum is zero.
//
// Reset clears the state machine, the output valid and the registers to 3, 3, 4, 4;
// the memories are not cleared. When the receiver stalls, the finished result stays
// in the output register, loads are still accepted, and the next evaluation waits at
// its end until the output register is free.
`default_nettype none

module nurbs_surface_point_eval_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    nspe_item_if.sink                        i_item,
    nspe_result_if.source                    o_result,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [nspe_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                 i_pwdata,
    output logic      [31:0]                 o_prdata,
    output logic                             o_pready
);

    localparam int KA_W = nspe_pkg::KA_W;
    localparam int NA_W = nspe_pkg::NA_W;
    localparam int PT_W = nspe_pkg::PT_W;
    localparam int BLEN = nspe_pkg::BASIS_LEN;
    localparam int MAXP = nspe_pkg::MAX_POINTS;
    localparam int FB   = nspe_pkg::FRAC_BITS;

    // Configuration registers.
    logic [1:0] r_degree_u, r_degree_v;
    logic [4:0] r_points_u, r_points_v;

    // State machine.
    nspe_pkg::t_state r_state, n_state;

    // Memories.
    logic signed [31:0]  r_knot_u [nspe_pkg::KNOT_DEPTH];
    logic signed [31:0]  r_knot_v [nspe_pkg::KNOT_DEPTH];
    nspe_pkg::t_point    r_net    [nspe_pkg::NET_DEPTH];
    logic signed [31:0]  r_kd_u, r_kd_v;
    nspe_pkg::t_point    r_net_rd;

    // Basis sequencer.
    logic signed [31:0]  r_tu, r_tv;
    logic                r_axis;
    logic [KA_W-1:0]     r_bi;
    logic [1:0]          r_bk;
    logic [2:0]          r_rc;
    logic                r_term;
    logic signed [31:0]  r_kk [6];
    logic signed [63:0]  r_acc;
    logic signed [31:0]  r_res;
    logic signed [31:0]  r_b  [BLEN];
    logic signed [31:0]  r_nu [MAXP];
    logic signed [31:0]  r_nv [MAXP];

    // Shared multiplier and divider.
    logic signed [63:0]  r_prod;
    logic [63:0]         r_rem, r_quo, r_dden;
    logic                r_dneg;
    logic [5:0]          r_dcnt;

    // Accumulation and results.
    logic [PT_W-1:0]     r_ci, r_cj;
    logic [NA_W-1:0]     r_idx;
    logic signed [31:0]  r_a;
    logic signed [63:0]  r_wsum, r_sx, r_sy, r_sz;
    logic [1:0]          r_fc;
    logic signed [31:0]  r_rx, r_ry, r_rz;
    logic                r_ovalid;
    logic signed [31:0]  r_ox, r_oy, r_oz;
    logic                r_ost;

    // Combinational helpers.
    logic                in_xfer, cfg_wr;
    logic [1:0]          ax_deg;
    logic [4:0]          ax_pts, pu_eff, pv_eff;
    logic [5:0]          ax_su, ax_cnt;
    logic signed [31:0]  ax_t, kd, ratio, tap, uv_val, a_val;
    logic signed [32:0]  num33, den33;
    logic                end_one, k0_one, basis_done, axis_done, acc_last;
    logic                div_start, div_step;
    logic signed [63:0]  div_num, div_den;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  mul_p;
    logic [KA_W-1:0]     kaddr;
    logic [63:0]         rem_sh;
    logic                rem_ge;
    logic signed [63:0]  fsum;

    assign in_xfer  = i_item.valid && i_item.ready;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready = 1'b1;
    assign i_item.ready = (r_state == nspe_pkg::ST_IDLE);

    assign o_result.valid  = r_ovalid;
    assign o_result.out_x  = r_ox;
    assign o_result.out_y  = r_oy;
    assign o_result.out_z  = r_oz;
    assign o_result.status = r_ost;

    always_comb begin
        case (nspe_pkg::t_reg'(i_paddr[3:2]))
            nspe_pkg::REG_DEGREE_U: o_prdata = {30'd0, r_degree_u};
            nspe_pkg::REG_DEGREE_V: o_prdata = {30'd0, r_degree_v};
            nspe_pkg::REG_POINTS_U: o_prdata = {27'd0, r_points_u};
            nspe_pkg::REG_POINTS_V: o_prdata = {27'd0, r_points_v};
            default:                o_prdata = 32'd0;
        endcase
    end

    assign pu_eff = nspe_pkg::eff_points(r_points_u);
    assign pv_eff = nspe_pkg::eff_points(r_points_v);
    assign ax_deg = r_axis ? r_degree_v : r_degree_u;
    assign ax_pts = r_axis ? pv_eff : pu_eff;
    assign ax_t   = r_axis ? r_tv : r_tu;
    assign ax_su  = 6'(ax_pts) + 6'(ax_deg) + 6'd1;
    assign ax_cnt = 6'(ax_pts) + 6'(ax_deg) - 6'(r_bk);
    assign kd     = r_axis ? r_kd_v : r_kd_u;

    // Knot slots held in r_kk: first, last, i, i+1, i+k, i+k+1.
    assign end_one = ((ax_t == r_kk[1]) && (6'(r_bi) + 6'(r_bk) + 6'd2 == ax_su))
                  || ((ax_t == r_kk[0]) && (r_bi == '0));
    assign k0_one  = (r_kk[2] <= ax_t) && (ax_t < r_kk[3]);

    // Operands of the current recursion term.
    assign num33 = r_term ? (33'(r_kk[5]) - 33'(ax_t)) : (33'(ax_t) - 33'(r_kk[2]));
    assign den33 = r_term ? (33'(r_kk[5]) - 33'(r_kk[3])) : (33'(r_kk[4]) - 33'(r_kk[2]));
    assign tap   = r_term ? r_b[1] : r_b[0];
    assign ratio = nspe_pkg::sat_div(r_quo, r_dneg);

    assign basis_done = (r_bi == KA_W'(BLEN - 1)) && (r_bk == ax_deg);
    assign axis_done  = basis_done;
    assign acc_last   = (5'(r_ci) == pu_eff - 5'd1) && (5'(r_cj) == pv_eff - 5'd1);

    assign uv_val = nspe_pkg::sat32(r_prod >>> FB);
    assign a_val  = nspe_pkg::sat32(r_prod >>> FB);

    always_comb begin
        case (r_fc)
            2'd0:    fsum = r_sx;
            2'd1:    fsum = r_sy;
            default: fsum = r_sz;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            nspe_pkg::ST_IDLE: begin
                if (in_xfer && i_item.action == nspe_pkg::ACT_EVAL) begin
                    n_state = nspe_pkg::ST_BSTEP;
                end
            end
            nspe_pkg::ST_BSTEP: begin
                n_state = (6'(r_bi) < ax_cnt) ? nspe_pkg::ST_KREAD : nspe_pkg::ST_BROT;
            end
            nspe_pkg::ST_KREAD: begin
                if (r_rc == 3'd6) begin
                    n_state = nspe_pkg::ST_BCASE;
                end
            end
            nspe_pkg::ST_BCASE: begin
                n_state = (end_one || r_bk == 2'd0) ? nspe_pkg::ST_BROT : nspe_pkg::ST_BTERM;
            end
            nspe_pkg::ST_BTERM: begin
                if (den33 != '0) begin
                    n_state = nspe_pkg::ST_DIV;
                end else if (r_term) begin
                    n_state = nspe_pkg::ST_BROT;
                end
            end
            nspe_pkg::ST_DIV: begin
                if (r_dcnt == 6'd63) begin
                    n_state = nspe_pkg::ST_MUL;
                end
            end
            nspe_pkg::ST_MUL:  n_state = nspe_pkg::ST_MACC;
            nspe_pkg::ST_MACC: n_state = r_term ? nspe_pkg::ST_BROT : nspe_pkg::ST_BTERM;
            nspe_pkg::ST_BROT: begin
                if (axis_done && r_axis) begin
                    n_state = nspe_pkg::ST_ACC_UV;
                end else begin
                    n_state = nspe_pkg::ST_BSTEP;
                end
            end
            nspe_pkg::ST_ACC_UV:  n_state = nspe_pkg::ST_ACC_W;
            nspe_pkg::ST_ACC_W:   n_state = nspe_pkg::ST_ACC_A;
            nspe_pkg::ST_ACC_A:   n_state = nspe_pkg::ST_ACC_X;
            nspe_pkg::ST_ACC_X:   n_state = nspe_pkg::ST_ACC_Y;
            nspe_pkg::ST_ACC_Y:   n_state = nspe_pkg::ST_ACC_Z;
            nspe_pkg::ST_ACC_Z:   n_state = nspe_pkg::ST_ACC_NXT;
            nspe_pkg::ST_ACC_NXT: n_state = acc_last ? nspe_pkg::ST_FIN : nspe_pkg::ST_ACC_UV;
            nspe_pkg::ST_FIN: begin
                n_state = (r_wsum == '0) ? nspe_pkg::ST_OUT : nspe_pkg::ST_FSTART;
            end
            nspe_pkg::ST_FSTART: n_state = nspe_pkg::ST_FDIV;
            nspe_pkg::ST_FDIV: begin
                if (r_dcnt == 6'd63) begin
                    n_state = nspe_pkg::ST_FSTORE;
                end
            end
            nspe_pkg::ST_FSTORE: begin
                n_state = (r_fc == 2'd2) ? nspe_pkg::ST_OUT : nspe_pkg::ST_FSTART;
            end
            nspe_pkg::ST_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    n_state = nspe_pkg::ST_IDLE;
                end
            end
            default: n_state = nspe_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: knot read address, divider start, step and operands, and multiplier operands.
    always_comb begin
        kaddr     = '0;
        div_start = 1'b0;
        div_step  = 1'b0;
        div_num   = 64'(num33) <<< FB;
        div_den   = 64'(den33);
        mul_a     = 33'(ratio);
        mul_b     = 33'(tap);
        case (r_state)
            nspe_pkg::ST_KREAD: begin
                case (r_rc)
                    3'd0:    kaddr = '0;
                    3'd1:    kaddr = KA_W'(ax_su - 6'd1);
                    3'd2:    kaddr = r_bi;
                    3'd3:    kaddr = r_bi + KA_W'(1);
                    3'd4:    kaddr = r_bi + KA_W'(r_bk);
                    3'd5:    kaddr = r_bi + KA_W'(r_bk) + KA_W'(1);
                    default: kaddr = '0;
                endcase
            end
            nspe_pkg::ST_BTERM: div_start = (den33 != '0);
            nspe_pkg::ST_DIV:   div_step = 1'b1;
            nspe_pkg::ST_FDIV:  div_step = 1'b1;
            nspe_pkg::ST_FSTART: begin
                div_start = 1'b1;
                div_num   = fsum;
                div_den   = r_wsum;
            end
            nspe_pkg::ST_ACC_UV: begin
                mul_a = 33'(r_nu[0]);
                mul_b = 33'(r_nv[0]);
            end
            nspe_pkg::ST_ACC_W: begin
                mul_a = 33'(uv_val);
                mul_b = {1'b0, r_net_rd.w};
            end
            nspe_pkg::ST_ACC_X: begin
                mul_a = 33'(r_a);
                mul_b = 33'(r_net_rd.x);
            end
            nspe_pkg::ST_ACC_Y: begin
                mul_a = 33'(r_a);
                mul_b = 33'(r_net_rd.y);
            end
            nspe_pkg::ST_ACC_Z: begin
                mul_a = 33'(r_a);
                mul_b = 33'(r_net_rd.z);
            end
            default: begin
                kaddr = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign rem_sh = {r_rem[62:0], r_quo[63]};
    assign rem_ge = (rem_sh >= r_dden);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= nspe_pkg::ST_IDLE;
            r_ovalid   <= 1'b0;
            r_degree_u <= 2'd3;
            r_degree_v <= 2'd3;
            r_points_u <= 5'd4;
            r_points_v <= 5'd4;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (nspe_pkg::t_reg'(i_paddr[3:2]))
                    nspe_pkg::REG_DEGREE_U: r_degree_u <= i_pwdata[1:0];
                    nspe_pkg::REG_DEGREE_V: r_degree_v <= i_pwdata[1:0];
                    nspe_pkg::REG_POINTS_U: r_points_u <= i_pwdata[4:0];
                    nspe_pkg::REG_POINTS_V: r_points_v <= i_pwdata[4:0];
                    default: begin
                        r_points_v <= r_points_v;
                    end
                endcase
            end
            if (r_state == nspe_pkg::ST_OUT && (!r_ovalid || o_result.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Memories: one write port each and a registered read.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_item.action == nspe_pkg::ACT_LOAD_U
                && i_item.slot < 8'(nspe_pkg::KNOT_DEPTH)) begin
            r_knot_u[i_item.slot[KA_W-1:0]] <= i_item.knot;
        end
        if (in_xfer && i_item.action == nspe_pkg::ACT_LOAD_V
                && i_item.slot < 8'(nspe_pkg::KNOT_DEPTH)) begin
            r_knot_v[i_item.slot[KA_W-1:0]] <= i_item.knot;
        end
        r_kd_u <= r_knot_u[kaddr];
        r_kd_v <= r_knot_v[kaddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_item.action == nspe_pkg::ACT_LOAD_PT) begin
            r_net[i_item.slot[NA_W-1:0]] <= {i_item.px, i_item.py, i_item.pz, i_item.weight};
        end
        r_net_rd <= r_net[r_idx];
    end

    // Serial restoring divider on magnitudes, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_rem  <= '0;
            r_quo  <= nspe_pkg::abs64(div_num);
            r_dden <= nspe_pkg::abs64(div_den);
            r_dneg <= div_num[63] ^ div_den[63];
            r_dcnt <= '0;
        end else if (div_step) begin
            r_rem  <= rem_ge ? (rem_sh - r_dden) : rem_sh;
            r_quo  <= {r_quo[62:0], rem_ge};
            r_dcnt <= r_dcnt + 6'd1;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            nspe_pkg::ST_IDLE: begin
                r_tu   <= i_item.param_u;
                r_tv   <= i_item.param_v;
                r_axis <= 1'b0;
                r_bi   <= '0;
                r_bk   <= '0;
            end
            nspe_pkg::ST_BSTEP: begin
                r_rc  <= '0;
                r_res <= '0;
            end
            nspe_pkg::ST_KREAD: begin
                if (r_rc != 3'd0) begin
                    r_kk[r_rc - 3'd1] <= kd;
                end
                r_rc <= r_rc + 3'd1;
            end
            nspe_pkg::ST_BCASE: begin
                r_acc  <= '0;
                r_term <= 1'b0;
                if (end_one) begin
                    r_res <= nspe_pkg::FIX_ONE;
                end else begin
                    r_res <= k0_one ? nspe_pkg::FIX_ONE : '0;
                end
            end
            nspe_pkg::ST_BTERM: begin
                if (den33 == '0) begin
                    r_res  <= nspe_pkg::sat32(r_acc);
                    r_term <= 1'b1;
                end
            end
            nspe_pkg::ST_MUL: begin
                r_prod <= mul_p[63:0];
            end
            nspe_pkg::ST_MACC: begin
                r_acc  <= r_acc + (r_prod >>> FB);
                r_res  <= nspe_pkg::sat32(r_acc + (r_prod >>> FB));
                r_term <= 1'b1;
            end
            nspe_pkg::ST_BROT: begin
                for (int j = 0; j < BLEN - 1; j++) begin
                    r_b[j] <= r_b[j + 1];
                end
                r_b[BLEN - 1] <= r_res;
                if (r_bi == KA_W'(BLEN - 1)) begin
                    r_bi <= '0;
                    r_bk <= r_bk + 2'd1;
                end else begin
                    r_bi <= r_bi + KA_W'(1);
                end
                if (axis_done) begin
                    // After this rotation entry j of the row holds basis value j.
                    for (int j = 0; j < MAXP; j++) begin
                        if (r_axis) begin
                            r_nv[j] <= r_b[j + 1];
                        end else begin
                            r_nu[j] <= r_b[j + 1];
                        end
                    end
                    r_axis <= 1'b1;
                    r_bk   <= '0;
                    r_ci   <= '0;
                    r_cj   <= '0;
                    r_idx  <= '0;
                    r_wsum <= '0;
                    r_sx   <= '0;
                    r_sy   <= '0;
                    r_sz   <= '0;
                end
            end
            nspe_pkg::ST_ACC_UV: r_prod <= mul_p[63:0];
            nspe_pkg::ST_ACC_W:  r_prod <= mul_p[63:0];
            nspe_pkg::ST_ACC_A: begin
                r_a    <= a_val;
                r_wsum <= r_wsum + 64'(a_val);
            end
            nspe_pkg::ST_ACC_X: r_prod <= mul_p[63:0];
            nspe_pkg::ST_ACC_Y: begin
                r_sx   <= nspe_pkg::sat_add64(r_sx, r_prod);
                r_prod <= mul_p[63:0];
            end
            nspe_pkg::ST_ACC_Z: begin
                r_sy   <= nspe_pkg::sat_add64(r_sy, r_prod);
                r_prod <= mul_p[63:0];
            end
            nspe_pkg::ST_ACC_NXT: begin
                r_sz  <= nspe_pkg::sat_add64(r_sz, r_prod);
                r_idx <= r_idx + NA_W'(1);
                // The v row rotates over pv entries; the u row advances once per row.
                for (int j = 0; j < MAXP; j++) begin
                    if (5'(j) == pv_eff - 5'd1 || j == MAXP - 1) begin
                        r_nv[j] <= r_nv[0];
                    end else begin
                        r_nv[j] <= r_nv[j + 1];
                    end
                end
                if (5'(r_cj) == pv_eff - 5'd1) begin
                    r_cj <= '0;
                    r_ci <= r_ci + PT_W'(1);
                    for (int j = 0; j < MAXP - 1; j++) begin
                        r_nu[j] <= r_nu[j + 1];
                    end
                    r_nu[MAXP - 1] <= '0;
                end else begin
                    r_cj <= r_cj + PT_W'(1);
                end
                r_fc <= '0;
            end
            nspe_pkg::ST_FIN: begin
                r_rx <= '0;
                r_ry <= '0;
                r_rz <= '0;
                r_fc <= '0;
            end
            nspe_pkg::ST_FSTORE: begin
                case (r_fc)
                    2'd0:    r_rx <= ratio;
                    2'd1:    r_ry <= ratio;
                    default: r_rz <= ratio;
                endcase
                r_fc <= r_fc + 2'd1;
            end
            nspe_pkg::ST_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    r_ox  <= r_rx;
                    r_oy  <= r_ry;
                    r_oz  <= r_rz;
                    r_ost <= (r_wsum == '0);
                end
            end
            default: begin
                r_rc <= r_rc;
            end
        endcase
    end

endmodule

`default_nettype wire
